/* sv/bresenham_line_address_gen_defines.svh */
// ----------------------------------------------------------------------------
// Bresenham line address generator: assertion macros
// Shared concurrent assertion forms, all clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_ADDRESS_GEN_DEFINES_SVH
`define BRESENHAM_LINE_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication.
`define BLAG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line address generator: same-cycle check failed");

// Next-cycle implication.
`define BLAG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line address generator: next-cycle check failed");

`endif

/* sv/blag_pkg.sv */
// ----------------------------------------------------------------------------
// Bresenham line address generator package
// Command word layout, register indexes and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blag_pkg;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        REG_ROW_STRIDE = 2'd0,
        REG_FORE_COLOR = 2'd1,
        REG_RASTER_OP  = 2'd2,
        REG_PLANE_MASK = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic               command;
        logic [11:0]        start_x;
        logic [11:0]        start_y;
        logic               x_negative;
        logic               y_negative;
        logic               major_is_x;
        logic signed [15:0] error_init;
        logic signed [15:0] error_axial;
        logic signed [15:0] error_diagonal;
        logic [12:0]        pixel_count;
    } t_line_cmd;

    localparam int CMD_W     = $bits(t_line_cmd);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int STRIDE_W  = 13;
    localparam int COUNT_W   = 13;
    // Signed step width: x step plus or minus the largest stride.
    localparam int STEP_W    = 15;

    localparam logic [3:0]  ROP_COPY    = 4'd3;
    localparam logic [7:0]  FULL_PLANES = 8'hFF;
    localparam logic [12:0] STRIDE_RST  = 13'd1024;

endpackage

`default_nettype wire

/* sv/blag_stream_if.sv */
// ----------------------------------------------------------------------------
// Bresenham line address generator stream interface
// Valid/ready channel carrying one flat data word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface blag_stream_if #(
    parameter int DATA_W = 8
);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/bresenham_line_address_gen.sv */
// ----------------------------------------------------------------------------
// Bresenham line address generator
// Turns start and step commands into frame-buffer byte addresses of a line.
// ----------------------------------------------------------------------------
// The block takes one command word per clock and answers a start, or a step
// while pixels remain, with one pixel word that appears in the output
// register on the next clock. A step after the last pixel gives no word.
// Throughput is one command per cycle for as long as the output side takes
// words; a full output register that is not being taken holds off the input.
// The longest path is the start address, a 12 by 13 bit multiply and add,
// which shares the cycle with the per-pixel address and error adds.
// The output word is {last, direct_write, pixel_value[7:0],
// pixel_address[ADDR_BITS-1:0]}; the command word is blag_pkg::t_line_cmd.
`timescale 1ns / 1ps
`default_nettype none

`include "bresenham_line_address_gen_defines.svh"

module bresenham_line_address_gen #(
    parameter int ADDR_BITS = 24,
    parameter int ERR_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [blag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [blag_pkg::CFG_DAT_W-1:0] i_cfg_data,
    blag_stream_if.sink                         i_cmd,
    blag_stream_if.source                       o_pix
);
    import blag_pkg::*;

    localparam int OUT_W = ADDR_BITS + 10;

    // Configuration registers.
    logic [STRIDE_W-1:0] r_row_stride;
    logic [7:0]          r_fore_color;
    logic [3:0]          r_raster_op;
    logic [7:0]          r_plane_mask;

    // Line state.
    logic [ADDR_BITS-1:0] r_cur_address, n_cur_address;
    logic [ERR_BITS-1:0]  r_err_term, n_err_term;
    logic [ERR_BITS-1:0]  r_inc_axial, n_inc_axial;
    logic [ERR_BITS-1:0]  r_inc_diagonal, n_inc_diagonal;
    logic [STEP_W-1:0]    r_step_diagonal, n_step_diagonal;
    logic [STEP_W-1:0]    r_step_axial, n_step_axial;
    logic [COUNT_W-1:0]   r_pixels_left, n_pixels_left;

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    t_line_cmd            w_cmd;
    logic                 w_accept;
    logic                 w_is_start;
    logic                 w_emit;
    logic                 w_diag;
    logic [24:0]          w_prod;
    logic [31:0]          w_start_sum;
    logic [STEP_W-1:0]    w_xs;
    logic [STEP_W-1:0]    w_ys;
    logic [STEP_W-1:0]    w_step_sel;
    logic [COUNT_W-1:0]   w_count;
    logic                 w_direct;

    function automatic logic [ERR_BITS-1:0] err_ext(input logic [15:0] v);
        logic [31:0] t;
        t = {{16{v[15]}}, v};
        return t[ERR_BITS-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] step_ext(input logic [STEP_W-1:0] s);
        return {{(ADDR_BITS - STEP_W){s[STEP_W-1]}}, s};
    endfunction

    assign w_cmd      = t_line_cmd'(i_cmd.data);
    assign i_cmd.ready = !r_out_valid || o_pix.ready;
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_is_start = (w_cmd.command == CMD_START);
    assign w_emit     = w_accept && (w_is_start || (r_pixels_left != '0));

    // Start path.
    assign w_prod      = w_cmd.start_y * r_row_stride;
    assign w_start_sum = 32'(w_prod) + 32'(w_cmd.start_x);
    assign w_xs        = w_cmd.x_negative ? {STEP_W{1'b1}} : STEP_W'(1);
    assign w_ys        = w_cmd.y_negative ? (STEP_W'(0) - STEP_W'(r_row_stride))
                                          : STEP_W'(r_row_stride);
    assign w_count     = (w_cmd.pixel_count == '0) ? COUNT_W'(1) : w_cmd.pixel_count;

    // Step path: a diagonal move when the error term is strictly positive.
    assign w_diag     = (r_err_term != '0) && !r_err_term[ERR_BITS-1];
    assign w_step_sel = w_diag ? r_step_diagonal : r_step_axial;

    assign w_direct = (r_raster_op == ROP_COPY) && (r_plane_mask == FULL_PLANES);

    always_comb begin
        n_cur_address   = r_cur_address;
        n_err_term      = r_err_term;
        n_inc_axial     = r_inc_axial;
        n_inc_diagonal  = r_inc_diagonal;
        n_step_diagonal = r_step_diagonal;
        n_step_axial    = r_step_axial;
        n_pixels_left   = r_pixels_left;
        if (w_accept && w_is_start) begin
            n_cur_address   = w_start_sum[ADDR_BITS-1:0];
            n_step_diagonal = w_xs + w_ys;
            n_step_axial    = w_cmd.major_is_x ? w_xs : w_ys;
            n_err_term      = err_ext(w_cmd.error_init);
            n_inc_axial     = err_ext(w_cmd.error_axial);
            n_inc_diagonal  = err_ext(w_cmd.error_diagonal);
            n_pixels_left   = w_count - COUNT_W'(1);
        end else if (w_emit) begin
            n_cur_address = r_cur_address + step_ext(w_step_sel);
            n_err_term    = r_err_term + (w_diag ? r_inc_diagonal : r_inc_axial);
            n_pixels_left = r_pixels_left - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_stride    <= STRIDE_RST;
            r_fore_color    <= '0;
            r_raster_op     <= ROP_COPY;
            r_plane_mask    <= FULL_PLANES;
            r_cur_address   <= '0;
            r_err_term      <= '0;
            r_inc_axial     <= '0;
            r_inc_diagonal  <= '0;
            r_step_diagonal <= '0;
            r_step_axial    <= '0;
            r_pixels_left   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_ROW_STRIDE: r_row_stride <= i_cfg_data;
                    REG_FORE_COLOR: r_fore_color <= i_cfg_data[7:0];
                    REG_RASTER_OP:  r_raster_op  <= i_cfg_data[3:0];
                    REG_PLANE_MASK: r_plane_mask <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_cur_address   <= n_cur_address;
            r_err_term      <= n_err_term;
            r_inc_axial     <= n_inc_axial;
            r_inc_diagonal  <= n_inc_diagonal;
            r_step_diagonal <= n_step_diagonal;
            r_step_axial    <= n_step_axial;
            r_pixels_left   <= n_pixels_left;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {(n_pixels_left == '0), w_direct, r_fore_color, n_cur_address};
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out_data;

    `BLAG_ASSERT_NEXT(a_start_emits, w_accept && w_is_start, o_pix.valid)
    `BLAG_ASSERT_NEXT(a_spent_step_silent,
        w_accept && !w_is_start && (r_pixels_left == '0) && o_pix.ready, !o_pix.valid)
    `BLAG_ASSERT_NOW(a_last_matches_count, o_pix.valid,
        r_out_data[OUT_W-1] == (r_pixels_left == '0))
    `BLAG_ASSERT_NOW(a_ready_when_empty, !r_out_valid, i_cmd.ready)

endmodule

`default_nettype wire
